>>> hdl/cpra_pkg.sv
// Shared types and constants of the contiguous page run allocator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package cpra_pkg;

	localparam int ADDR_W = 39;
	localparam int LEN_W  = 32;
	localparam int STAT_W = 2;
	localparam int WORD_W = 64;

	// Request kinds carried on the input tuser.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes carried on the output tuser.
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;
	localparam logic [STAT_W-1:0] ST_UNALLOC = 2'd3;

	// Configuration register index (register i sits at byte address 8*i).
	localparam logic REG_REGION_BASE = 1'b0;

	typedef struct packed {
		logic              cmd;
		logic [LEN_W-1:0]  length_bytes;
		logic [ADDR_W-1:0] region_addr;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] alloc_addr;
	} res_t;

endpackage

>>> hdl/cpra_bitmap_ram.sv
// Page bitmap memory: one write port, one read port with registered data.
// Rows that were never written since reset read as all free. Uses cpra_pkg.
`timescale 1ns / 1ps

module cpra_bitmap_ram #(
	parameter int WORDS = 4,
	parameter int AW    = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [cpra_pkg::WORD_W-1:0] rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [cpra_pkg::WORD_W-1:0] wr_data
);
	import cpra_pkg::*;

	logic [WORD_W-1:0] mem [WORDS];
	logic [WORDS-1:0]  row_vld_q;
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Valid bits stand in for clearing the array at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_data_q <= '0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_data_q <= row_vld_q[rd_addr] ? mem[rd_addr] : '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/cpra_cfg.sv
// APB-style configuration register block holding region_base.
// Uses cpra_pkg for widths and the register index.
`timescale 1ns / 1ps

module cpra_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	output logic [cpra_pkg::ADDR_W-1:0] region_base
);
	import cpra_pkg::*;

	logic [ADDR_W-1:0] region_base_q;
	logic              reg_idx;
	logic              wr_hit;

	// Registers are 8 bytes apart, so bit 3 selects the register.
	assign reg_idx = paddr[3];
	assign pready  = 1'b1;
	assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == REG_REGION_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
		end else if (wr_hit) begin
			region_base_q <= pwdata[ADDR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_REGION_BASE) begin
			prdata = 64'(region_base_q);
		end
	end

	assign region_base = region_base_q;

endmodule

>>> hdl/cpra_engine.sv
// Allocation sequencer: checks a request, scans or clears the page bitmap one
// bit per cycle between word loads, marks runs by word. Uses cpra_bitmap_ram, cpra_pkg.
`timescale 1ns / 1ps

module cpra_engine #(
	parameter int NUM_PAGES  = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cpra_pkg::ADDR_W-1:0] region_base,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  cpra_pkg::req_t              req,
	output logic                        res_valid,
	input  logic                        res_ready,
	output cpra_pkg::res_t              res
);
	import cpra_pkg::*;

	localparam int PS    = $clog2(PAGE_BYTES);
	localparam int PG_W  = $clog2(NUM_PAGES) + 1;
	localparam int WORDS = (NUM_PAGES + 63) / 64;
	localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [LEN_W:0]  MAX_LEN = (LEN_W + 1)'(NUM_PAGES * PAGE_BYTES);
	localparam logic [PG_W-1:0] LAST_PG = PG_W'(NUM_PAGES);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK1 = 4'd1;
	localparam logic [3:0] S_CHK2 = 4'd2;
	localparam logic [3:0] S_RD   = 4'd3;
	localparam logic [3:0] S_LD   = 4'd4;
	localparam logic [3:0] S_SCAN = 4'd5;
	localparam logic [3:0] S_FREE = 4'd6;
	localparam logic [3:0] S_MRD  = 4'd7;
	localparam logic [3:0] S_MWR  = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]        state_q;
	logic              cmd_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] off_q;
	logic [PG_W-1:0]   npg_q;
	logic [PG_W-1:0]   first_q;
	logic [PG_W-1:0]   cur_q;
	logic [PG_W-1:0]   end_q;
	logic [WA_W-1:0]   mw_q;
	logic [WORD_W-1:0] word_q;
	res_t              res_q;

	// Memory port signals.
	logic              rd_en;
	logic [WA_W-1:0]   rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic              wr_en;
	logic [WA_W-1:0]   wr_addr;
	logic [WORD_W-1:0] wr_data;

	logic [WA_W-1:0]   cur_w;
	logic [WA_W-1:0]   first_w;
	logic [PG_W-1:0]   cur_nx;
	logic              cur_bit;
	logic [WORD_W-1:0] word_clr;
	logic [5:0]        mask_lo;
	logic [5:0]        mask_hi;
	logic [WORD_W-1:0] mask;
	logic              alloc_bad;
	logic              free_bad1;
	logic              free_bad2;
	logic [ADDR_W:0]   end_wide;

	assign cur_w    = WA_W'(cur_q >> 6);
	assign first_w  = WA_W'(first_q >> 6);
	assign cur_nx   = cur_q + 1'b1;
	assign cur_bit  = word_q[cur_q[5:0]];
	assign word_clr = word_q & ~(WORD_W'(1) << cur_q[5:0]);

	assign mask_lo = (mw_q == first_w) ? first_q[5:0] : 6'd0;
	assign mask_hi = (mw_q == cur_w) ? cur_q[5:0] : 6'd63;
	assign mask    = ({WORD_W{1'b1}} << mask_lo) & ({WORD_W{1'b1}} >> (6'd63 - mask_hi));

	assign alloc_bad = (len_q == '0) || (len_q[PS-1:0] != '0) || ({1'b0, len_q} > MAX_LEN);
	assign free_bad1 = (len_q == '0) || (len_q[PS-1:0] != '0) || (addr_q < region_base);
	assign end_wide  = (ADDR_W + 1)'(off_q >> PS) + (ADDR_W + 1)'(len_q >> PS);
	assign free_bad2 = (off_q[PS-1:0] != '0) || (end_wide > (ADDR_W + 1)'(NUM_PAGES));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_w;
		wr_en   = 1'b0;
		wr_addr = cur_w;
		wr_data = word_clr;
		case (state_q)
			S_RD: begin
				rd_en = 1'b1;
			end
			S_MRD: begin
				rd_en   = 1'b1;
				rd_addr = mw_q;
			end
			S_MWR: begin
				wr_en   = 1'b1;
				wr_addr = mw_q;
				wr_data = rd_data | mask;
			end
			S_FREE: begin
				// Write back when stopping or leaving the current word.
				if (!cur_bit) begin
					wr_en   = 1'b1;
					wr_data = word_q;
				end else if (cur_nx == end_q || cur_q[5:0] == 6'd63) begin
					wr_en = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHK1;
					end
				end
				S_CHK1: begin
					if (cmd_q == CMD_ALLOC) begin
						state_q <= alloc_bad ? S_DONE : S_RD;
					end else begin
						state_q <= free_bad1 ? S_DONE : S_CHK2;
					end
				end
				S_CHK2: begin
					state_q <= free_bad2 ? S_DONE : S_RD;
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					state_q <= (cmd_q == CMD_ALLOC) ? S_SCAN : S_FREE;
				end
				S_SCAN: begin
					if (!cur_bit && (cur_nx - first_q) == npg_q) begin
						state_q <= S_MRD;
					end else if (cur_nx == LAST_PG) begin
						state_q <= S_DONE;
					end else if (cur_q[5:0] == 6'd63) begin
						state_q <= S_RD;
					end
				end
				S_FREE: begin
					if (!cur_bit || cur_nx == end_q) begin
						state_q <= S_DONE;
					end else if (cur_q[5:0] == 6'd63) begin
						state_q <= S_RD;
					end
				end
				S_MRD: begin
					state_q <= S_MWR;
				end
				S_MWR: begin
					state_q <= (mw_q == cur_w) ? S_DONE : S_MRD;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers follow the sequencer state.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q   <= req.cmd;
				len_q   <= req.length_bytes;
				addr_q  <= req.region_addr;
				cur_q   <= '0;
				first_q <= '0;
			end
			S_CHK1: begin
				off_q  <= addr_q - region_base;
				npg_q  <= PG_W'(len_q >> PS);
				res_q  <= '{status: ST_BAD, alloc_addr: '0};
			end
			S_CHK2: begin
				cur_q <= PG_W'(off_q >> PS);
				end_q <= PG_W'(end_wide);
			end
			S_LD: begin
				word_q <= rd_data;
			end
			S_SCAN: begin
				if (!cur_bit && (cur_nx - first_q) == npg_q) begin
					mw_q <= first_w;
				end else begin
					if (cur_bit) begin
						first_q <= cur_nx;
					end
					cur_q <= cur_nx;
					if (cur_nx == LAST_PG) begin
						res_q <= '{status: ST_NOSPACE, alloc_addr: '0};
					end
				end
			end
			S_FREE: begin
				word_q <= word_clr;
				cur_q  <= cur_nx;
				if (!cur_bit) begin
					res_q <= '{status: ST_UNALLOC, alloc_addr: '0};
				end else if (cur_nx == end_q) begin
					res_q <= '{status: ST_OK, alloc_addr: '0};
				end
			end
			S_MWR: begin
				mw_q  <= mw_q + 1'b1;
				res_q <= '{status: ST_OK,
					alloc_addr: region_base + (ADDR_W'(first_q) << PS)};
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	cpra_bitmap_ram #(
		.WORDS (WORDS),
		.AW    (WA_W)
	) u_bitmap (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

>>> hdl/contiguous_page_run_allocator.sv
// Top level of the contiguous page run allocator: stream ports, APB port,
// result output register. Depends on cpra_pkg, cpra_cfg and cpra_engine.
//
//  Channel   Direction  Carries
//  s_axis    in         request: tuser = cmd, tdata = length_bytes, region_addr
//  m_axis    out        result: tuser = status, tdata = alloc_addr
//  apb       in/out     region_base register at byte address 0
//
// One request is worked on at a time. A request is checked in S_CHK1, and a free
// also in S_CHK2; then the sequencer walks the bitmap one page bit per cycle,
// pausing in S_RD and S_LD to load each 64-bit memory word. An allocate that
// finds a run then marks it a word at a time through S_MRD and S_MWR; a free
// clears the pages of its run as it walks, stopping at the first unused page.
// Reset clears the bitmap at once through per-word valid bits. A stalled output
// only holds the next result once the output register is full.
`timescale 1ns / 1ps

module contiguous_page_run_allocator #(
	parameter int NUM_PAGES  = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // [31:0] length_bytes, [70:32] region_addr, [71] zero
	input  logic [0:0]  s_axis_tuser,   // [0] cmd
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [38:0] alloc_addr, [39] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import cpra_pkg::*;

	logic [ADDR_W-1:0] region_base;
	req_t              req;
	logic              res_valid;
	logic              res_ready;
	res_t              res;
	logic              m_valid_q;
	res_t              m_res_q;

	// Unpack the request; the pad bit of tdata carries nothing.
	assign req.cmd          = s_axis_tuser[0];
	assign req.length_bytes = s_axis_tdata[LEN_W-1:0];
	assign req.region_addr  = s_axis_tdata[LEN_W+ADDR_W-1:LEN_W];

	cpra_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.region_base (region_base)
	);

	cpra_engine #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.region_base (region_base),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req         (req),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// The output register takes a new result whenever it is empty or being
	// drained in the same cycle, so the sequencer can go back to idle and
	// accept the next request while a result waits downstream.
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_res_q.alloc_addr};
	assign m_axis_tuser  = m_res_q.status;

endmodule

>>> tb/cpra_checker.sv
// Scoreboard for the contiguous page run allocator: keeps its own page map and base register,
// predicts one result per accepted request and compares the result stream against it.
// Depends on cpra_pkg for the request, result and status definitions.
`timescale 1ns / 1ps

module cpra_checker #(
	parameter int NUM_PAGES  = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // [31:0] length_bytes, [70:32] region_addr, [71] zero
	input  logic [0:0]  s_axis_tuser,   // [0] cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,   // [38:0] alloc_addr, [39] zero
	input  logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic [63:0] prdata,
	input  logic        pready,
	output int          mismatches,
	output int          awaited,
	output int          ok_count,
	output int          bad_count,
	output int          full_count,
	output int          unalloc_count
);
	import cpra_pkg::*;

	logic [NUM_PAGES-1:0] page_used;
	logic [ADDR_W-1:0]    region_base;
	res_t                 results_due[$];

	task automatic note_failure(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch at %0t ns: %s", $time, msg);
		end
	endtask

	// Applies one request to the page map and returns the result it must produce.
	function automatic res_t serve_request(input req_t rq);
		res_t            r;
		int unsigned     npg;
		int unsigned     first;
		bit              found;
		longint unsigned off;
		longint unsigned pg;
		longint unsigned stop;
		r.status     = ST_OK;
		r.alloc_addr = '0;
		if (rq.cmd == CMD_ALLOC) begin
			if (rq.length_bytes == 0 || rq.length_bytes % PAGE_BYTES != 0 ||
					rq.length_bytes > NUM_PAGES * PAGE_BYTES) begin
				r.status = ST_BAD;
			end else begin
				npg   = rq.length_bytes / PAGE_BYTES;
				first = 0;
				found = 1'b0;
				for (int unsigned cur = 0; cur < NUM_PAGES; cur++) begin
					if (!found) begin
						if (page_used[cur]) begin
							first = cur + 1;
						end
						if (cur + 1 - first == npg) begin
							for (int unsigned k = first; k <= cur; k++) begin
								page_used[k] = 1'b1;
							end
							r.alloc_addr = region_base + ADDR_W'(longint'(first) * PAGE_BYTES);
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					r.status = ST_NOSPACE;
				end
			end
		end else begin
			if (rq.length_bytes == 0 || rq.length_bytes % PAGE_BYTES != 0 ||
					rq.region_addr < region_base) begin
				r.status = ST_BAD;
			end else begin
				off  = rq.region_addr - region_base;
				pg   = off / PAGE_BYTES;
				stop = pg + rq.length_bytes / PAGE_BYTES;
				if (off % PAGE_BYTES != 0 || stop > NUM_PAGES) begin
					r.status = ST_BAD;
				end else begin
					// Pages are cleared in order; an unused page ends the walk.
					while (pg < stop && r.status == ST_OK) begin
						if (!page_used[pg]) begin
							r.status = ST_UNALLOC;
						end else begin
							page_used[pg] = 1'b0;
							pg++;
						end
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			page_used   = '0;
			region_base = '0;
			results_due.delete();
			awaited     = 0;
		end else begin
			if (psel && penable && pready && paddr[3] == REG_REGION_BASE) begin
				if (pwrite) begin
					region_base = pwdata[ADDR_W-1:0];
				end else if (prdata !== 64'(region_base)) begin
					note_failure($sformatf("region_base read: expected %h, actual %h",
						64'(region_base), prdata));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				results_due.push_back(serve_request(req_t'({s_axis_tuser[0],
					s_axis_tdata[31:0], s_axis_tdata[70:32]})));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status     = m_axis_tuser;
				got.alloc_addr = m_axis_tdata[ADDR_W-1:0];
				case (got.status)
					ST_OK:      ok_count++;
					ST_BAD:     bad_count++;
					ST_NOSPACE: full_count++;
					ST_UNALLOC: unalloc_count++;
					default:    ;
				endcase
				if (results_due.size() == 0) begin
					note_failure($sformatf("result with nothing awaited: status %0d, alloc_addr %h",
						got.status, got.alloc_addr));
				end else begin
					want = results_due.pop_front();
					if (got.status !== want.status || got.alloc_addr !== want.alloc_addr) begin
						note_failure($sformatf(
							"status expected %0d actual %0d, alloc_addr expected %h actual %h",
							want.status, got.status, want.alloc_addr, got.alloc_addr));
					end
				end
			end
			awaited = results_due.size();
		end
	end

endmodule

>>> tb/tb_contiguous_page_run_allocator.sv
// Testbench top for the contiguous page run allocator: clock, reset, request and APB stimulus,
// result-side back-pressure and the final verdict. Depends on cpra_pkg, cpra_checker and the RTL.
`timescale 1ns / 1ps

module tb_contiguous_page_run_allocator;
	import cpra_pkg::*;

	localparam int NUM_PAGES  = 256;
	localparam int PAGE_BYTES = 4096;

	// Worst-case time for one request to come out: a full bitmap scan plus the word loads.
	localparam int LATENCY_CYCLES = NUM_PAGES + NUM_PAGES / 32 + 2 * (NUM_PAGES / 64) + 32;

	// Register 0 sits at byte address 0; address 8 would be register 1, which does not exist.
	localparam logic [3:0] BASE_REG_ADDR   = {REG_REGION_BASE, 3'b000};
	localparam logic [3:0] UNUSED_REG_ADDR = 4'b1000;

	localparam logic [ADDR_W-1:0] DIRECTED_BASE = 39'h10_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;   // [31:0] length_bytes, [70:32] region_addr, [71] zero
	logic [0:0]  s_axis_tuser = '0;   // [0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;        // [38:0] alloc_addr, [39] zero
	logic [1:0]  m_axis_tuser;        // [1:0] status
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	int mismatches;
	int awaited;
	int ok_count;
	int bad_count;
	int full_count;
	int unalloc_count;

	// Stimulus state: requests waiting to go out, the idle and stall rates of the
	// current phase, the base address the block was last given, and the length
	// of a pending long hold-off on the result side.
	req_t              outbox[$];
	int                send_idle = 0;
	int                recv_stall = 0;
	int                hold_left = 0;
	int                sent = 0;
	logic [ADDR_W-1:0] cur_base = '0;

	always #1 clk = ~clk;

	contiguous_page_run_allocator #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	cpra_checker #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.awaited      (awaited),
		.ok_count     (ok_count),
		.bad_count    (bad_count),
		.full_count   (full_count),
		.unalloc_count(unalloc_count)
	);

	// One APB transfer: a setup cycle, then the access cycle held until pready.
	task automatic apb_access(input logic wr, input logic [3:0] addr, input logic [63:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Writes the base register, remembers what the block keeps of it, and reads it back
	// so the checker can compare the read data.
	task automatic set_region_base(input logic [63:0] value);
		apb_access(1'b1, BASE_REG_ADDR, value);
		cur_base = value[ADDR_W-1:0];
		apb_access(1'b0, BASE_REG_ADDR, '0);
	endtask

	task automatic queue_request(input logic cmd, input logic [LEN_W-1:0] len,
			input logic [ADDR_W-1:0] addr);
		req_t rq;
		rq.cmd          = cmd;
		rq.length_bytes = len;
		rq.region_addr  = addr;
		outbox.push_back(rq);
	endtask

	// Random request. Most are well-formed allocates and frees of page-aligned runs so that
	// the page map fills, fragments and drains; frees aim at pages relative to the current
	// base so they often land on used pages. The rest is noise and slightly broken requests.
	function automatic req_t make_request();
		req_t        rq;
		int unsigned pick;
		int unsigned shape;
		int unsigned pages;
		int unsigned start;
		int unsigned broken;
		pick   = $urandom_range(99);
		shape  = $urandom_range(99);
		broken = $urandom_range(99);
		rq.cmd          = (pick < 55) ? CMD_ALLOC : CMD_FREE;
		rq.length_bytes = '0;
		rq.region_addr  = ADDR_W'({$urandom, $urandom});
		if (pick < 10) begin
			rq.cmd          = 1'($urandom_range(1));
			rq.length_bytes = $urandom;
		end else if (rq.cmd == CMD_ALLOC) begin
			// Mostly short runs; a few span large parts of the region.
			pages = (shape < 70) ? $urandom_range(8, 1) :
				(shape < 95) ? $urandom_range(64, 1) : $urandom_range(NUM_PAGES, 1);
			rq.length_bytes = LEN_W'(pages * PAGE_BYTES);
			if (broken < 5) begin
				rq.length_bytes += $urandom_range(PAGE_BYTES - 1, 1);
			end
		end else begin
			start = $urandom_range(NUM_PAGES - 1);
			pages = (shape < 80) ? $urandom_range(4, 1) :
				(shape < 97) ? $urandom_range(32, 1) : $urandom_range(NUM_PAGES, 1);
			rq.length_bytes = LEN_W'(pages * PAGE_BYTES);
			rq.region_addr  = cur_base + ADDR_W'(start * PAGE_BYTES);
			if (broken < 4) begin
				rq.length_bytes += $urandom_range(PAGE_BYTES - 1, 1);
			end else if (broken < 8) begin
				rq.region_addr += $urandom_range(PAGE_BYTES - 1, 1);
			end
		end
		return rq;
	endfunction

	// Sends everything in the outbox. Before each request the sender may go idle at the
	// phase's idle rate; otherwise valid stays high and the next request follows directly.
	task automatic send_outbox();
		req_t rq;
		while (outbox.size() > 0) begin
			rq = outbox.pop_front();
			while ($urandom_range(99) < send_idle) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {1'b0, rq.region_addr, rq.length_bytes};
			s_axis_tuser  <= rq.cmd;
			do @(posedge clk); while (!s_axis_tready);
			sent++;
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// The checker updates on the rising edge, so its count is read on the falling edge.
	task automatic wait_idle();
		do @(negedge clk); while (awaited != 0);
	endtask

	task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
		send_idle  = idle_pct;
		recv_stall = stall_pct;
		repeat (items) outbox.push_back(make_request());
		send_outbox();
		wait_idle();
	endtask

	// Result side: random stalls at the phase's rate, or a solid hold-off while one is pending.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// A write to a register that does not exist must leave the base alone; the checker
		// ignores it as well, and the following write sets the base before the read-back.
		apb_access(1'b1, UNUSED_REG_ADDR, '1);
		set_region_base(64'(DIRECTED_BASE));

		// Directed part. Allocate with a bad length: zero, not page aligned, all ones, and
		// one page more than the region holds.
		queue_request(CMD_ALLOC, '0, '0);
		queue_request(CMD_ALLOC, LEN_W'(PAGE_BYTES + 1), '0);
		queue_request(CMD_ALLOC, '1, '0);
		queue_request(CMD_ALLOC, LEN_W'((NUM_PAGES + 1) * PAGE_BYTES), '0);
		// A single page at the bottom; the address field of an allocate is ignored.
		queue_request(CMD_ALLOC, LEN_W'(PAGE_BYTES), '1);
		// The whole region no longer fits.
		queue_request(CMD_ALLOC, LEN_W'(NUM_PAGES * PAGE_BYTES), '0);
		queue_request(CMD_FREE, LEN_W'(PAGE_BYTES), DIRECTED_BASE);
		// Now the whole region fits, after which not even one page does.
		queue_request(CMD_ALLOC, LEN_W'(NUM_PAGES * PAGE_BYTES), '0);
		queue_request(CMD_ALLOC, LEN_W'(PAGE_BYTES), '0);
		// Free with bad arguments: address below the base, offset not page aligned, zero
		// length, length not page aligned, run past the last page, and all bits set.
		queue_request(CMD_FREE, LEN_W'(PAGE_BYTES), '0);
		queue_request(CMD_FREE, LEN_W'(PAGE_BYTES), DIRECTED_BASE + 39'h800);
		queue_request(CMD_FREE, '0, DIRECTED_BASE);
		queue_request(CMD_FREE, LEN_W'(PAGE_BYTES + 5), DIRECTED_BASE);
		queue_request(CMD_FREE, LEN_W'(2 * PAGE_BYTES),
			DIRECTED_BASE + ADDR_W'((NUM_PAGES - 1) * PAGE_BYTES));
		queue_request(CMD_FREE, '1, '1);
		// Clear the whole region, then free a page that is no longer in use.
		queue_request(CMD_FREE, LEN_W'(NUM_PAGES * PAGE_BYTES), DIRECTED_BASE);
		queue_request(CMD_FREE, LEN_W'(PAGE_BYTES), DIRECTED_BASE + ADDR_W'(3 * PAGE_BYTES));
		// A free that runs past its allocation clears the used pages before stopping;
		// the next allocates must find those pages free again.
		queue_request(CMD_ALLOC, LEN_W'(3 * PAGE_BYTES), '0);
		queue_request(CMD_FREE, LEN_W'(5 * PAGE_BYTES), DIRECTED_BASE);
		queue_request(CMD_ALLOC, LEN_W'(2 * PAGE_BYTES), '0);
		queue_request(CMD_ALLOC, LEN_W'(PAGE_BYTES), '0);
		queue_request(CMD_FREE, LEN_W'(3 * PAGE_BYTES), DIRECTED_BASE);
		queue_request(CMD_FREE, LEN_W'(PAGE_BYTES),
			DIRECTED_BASE + ADDR_W'((NUM_PAGES - 1) * PAGE_BYTES));
		send_outbox();
		wait_idle();

		// Random phases. Each base address below is set while the block is idle.
		set_region_base(64'($urandom) << 12);
		run_phase(400, 0, 0);

		// All ones: the bits above the register width must be dropped, and allocated
		// addresses wrap past the top of the address space.
		set_region_base('1);
		run_phase(300, 73, 0);

		// Upper bits set, register bits clear: the base becomes zero.
		set_region_base(64'hFFFF_FF80_0000_0000);
		run_phase(300, 0, 73);

		// Unaligned random base. First the result side holds off for a long stretch while
		// the sender keeps offering requests, so the block fills and stops taking input.
		set_region_base({$urandom, $urandom});
		hold_left = 3000;
		run_phase(30, 0, 0);
		run_phase(300, 10, 10);

		// Base just below the top, so runs in the upper pages wrap around.
		set_region_base(64'((64'd1 << ADDR_W) - 64 * PAGE_BYTES));
		run_phase(400, 0, 0);

		repeat (LATENCY_CYCLES) @(posedge clk);

		$display("Covered %0d requests over six base settings, sender and receiver stalls and a long output hold.",
			sent);
		$display("Results seen: %0d ok, %0d rejected, %0d without room, %0d stopped at a free page.",
			ok_count, bad_count, full_count, unalloc_count);
		if (mismatches == 0 && awaited == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Timeout far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

>>> contiguous_page_run_allocator.f
hdl/cpra_pkg.sv
hdl/cpra_bitmap_ram.sv
hdl/cpra_cfg.sv
hdl/cpra_engine.sv
hdl/contiguous_page_run_allocator.sv
tb/cpra_checker.sv
tb/tb_contiguous_page_run_allocator.sv
